// ===== hw/rtl/hrd_pkg.sv =====
package hrd_pkg;

    localparam int HRD_MAX_BEATS = 32;

    localparam int TIME_W   = 32;
    localparam int SAMPLE_W = 10;
    localparam int THRESH_W = 10;
    localparam int BLANK_W  = 16;
    localparam int WINDOW_W = 20;
    localparam int COUNT_W  = 6;
    localparam int BPM_W    = 8;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 6'd63;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd511;
    localparam logic [BLANK_W-1:0]  BLANK_RESET  = 16'd200;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 20'd12200;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_BLANKING  = 2'd1,
        REG_WINDOW    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                shift;
        logic [TIME_W-1:0]   now;
        logic [WINDOW_W-1:0] window;
    } cell_ctrl_t;

    function automatic logic [BPM_W-1:0] rate_of(input logic [COUNT_W-1:0] count);
        logic [BPM_W-1:0] rate;
        case (count)
            6'd1:    rate = 8'd60;
            6'd2:    rate = 8'd120;
            6'd3:    rate = 8'd130;
            6'd4:    rate = 8'd140;
            6'd5:    rate = 8'd150;
            6'd6:    rate = 8'd160;
            6'd7:    rate = 8'd170;
            6'd8:    rate = 8'd180;
            6'd9:    rate = 8'd190;
            default: rate = 8'd0;
        endcase
        return rate;
    endfunction

endpackage

// ===== hw/rtl/heartbeat_rate_detector.sv =====
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: sample [9:0]
// m_        out  m_tvalid/m_tready  m_tdata: beat_count [5:0], bpm [13:6], bpm_valid [14]
// cfg_      in   cfg_we             cfg_index, cfg_wdata
//
// The per-cell age compares and the count of surviving cells settle in the
// cycle a sample is accepted, and the result of a beat appears in the output
// register on the next cycle.
// Reset is synchronous and empties the beat store and the output valid flag.
// A stalled result holds the input back only until the result is taken.
module heartbeat_rate_detector
    import hrd_pkg::*;
#(
    parameter int MAX_BEATS = HRD_MAX_BEATS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // sample [9:0], zero [15:10]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // beat_count [5:0], bpm [13:6], bpm_valid [14]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_BEATS + 1);

    logic [THRESH_W-1:0] thresh_reg;
    logic [BLANK_W-1:0]  blank_ticks_reg;
    logic [WINDOW_W-1:0] window_reg;

    logic [TIME_W-1:0]   tick_reg;
    logic [TIME_W-1:0]   last_beat_reg;
    logic                blank_reg;
    logic                blank_next;

    logic                m_tvalid_reg;
    logic                m_tvalid_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;

    logic                accept;
    logic                beat;
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   elapsed;
    cell_ctrl_t          ctrl;

    logic [TIME_W-1:0]    chain_time [MAX_BEATS];
    logic [MAX_BEATS-1:0] kept;
    logic [CNT_W-1:0]     kept_cnt;
    logic [CNT_W-1:0]     new_cnt;
    logic [CNT_W+COUNT_W-1:0] new_cnt_ext;

    assign sample   = s_tdata[SAMPLE_W-1:0];
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign elapsed  = tick_reg - last_beat_reg;
    assign beat     = accept && !blank_reg && (sample > thresh_reg);

    assign ctrl.shift  = beat;
    assign ctrl.now    = tick_reg;
    assign ctrl.window = window_reg;

    for (genvar i = 0; i < MAX_BEATS; i++) begin : g_cell
        if (i == 0) begin : g_head
            hrd_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .in_time  (tick_reg),
                .in_valid (1'b1),
                .out_time (chain_time[i]),
                .out_kept (kept[i])
            );
        end else begin : g_body
            hrd_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .in_time  (chain_time[i-1]),
                .in_valid (kept[i-1]),
                .out_time (chain_time[i]),
                .out_kept (kept[i])
            );
        end
    end

    // Newer beats sit nearer the head, so the surviving cells form a prefix
    // of the chain and the count is the position of its last cell.
    always_comb begin
        kept_cnt = '0;
        for (int i = 0; i < MAX_BEATS; i++) begin
            if (kept[i] && (i == MAX_BEATS - 1 || !kept[(i + 1) % MAX_BEATS])) begin
                kept_cnt = kept_cnt | CNT_W'(i + 1);
            end
        end
    end

    always_comb begin
        if (kept_cnt == CNT_W'(MAX_BEATS)) begin
            new_cnt = kept_cnt;
        end else begin
            new_cnt = kept_cnt + CNT_W'(1);
        end
        new_cnt_ext = (CNT_W + COUNT_W)'(new_cnt);
        if (new_cnt_ext > (CNT_W + COUNT_W)'(COUNT_LIMIT)) begin
            count_next = COUNT_LIMIT;
        end else begin
            count_next = new_cnt_ext[COUNT_W-1:0];
        end
    end

    always_comb begin
        blank_next = blank_reg;
        if (accept) begin
            if (blank_reg) begin
                if (elapsed > TIME_W'(blank_ticks_reg)) begin
                    blank_next = 1'b0;
                end
            end else if (beat) begin
                blank_next = 1'b1;
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (beat) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg      <= THRESH_RESET;
            blank_ticks_reg <= BLANK_RESET;
            window_reg      <= WINDOW_RESET;
            tick_reg        <= '0;
            last_beat_reg   <= '0;
            blank_reg       <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_THRESHOLD: thresh_reg      <= cfg_wdata[THRESH_W-1:0];
                    REG_BLANKING:  blank_ticks_reg <= cfg_wdata[BLANK_W-1:0];
                    REG_WINDOW:    window_reg      <= cfg_wdata[WINDOW_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                tick_reg <= tick_reg + TIME_W'(1);
            end
            if (beat) begin
                last_beat_reg <= tick_reg;
            end
            blank_reg    <= blank_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat) begin
            count_reg <= count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0,
                       (count_reg >= 6'd1) && (count_reg <= 6'd9),
                       rate_of(count_reg),
                       count_reg};

endmodule

// ===== hw/rtl/hrd_cell.sv =====
module hrd_cell
    import hrd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctrl_t        ctrl,
    input  logic [TIME_W-1:0] in_time,
    input  logic              in_valid,
    output logic [TIME_W-1:0] out_time,
    output logic              out_kept
);

    logic [TIME_W-1:0] time_reg;
    logic              valid_reg;
    logic [TIME_W-1:0] age;

    assign age      = ctrl.now - time_reg;
    assign out_kept = valid_reg && !(age > TIME_W'(ctrl.window));
    assign out_time = time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.shift) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            time_reg <= in_time;
        end
    end

endmodule

// ===== hw/rtl/hrd_checker.sv =====
module hrd_checker
    import hrd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A result that is not taken stays offered unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every result counts at least the beat that caused it.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[5:0] != 6'd0)
        else $error("beat count of zero");

    // The rate flag agrees with the count and the table rate.
    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14] == ((m_tdata[5:0] >= 6'd1) && (m_tdata[5:0] <= 6'd9)))
                     && (m_tdata[14] == (m_tdata[13:6] != 8'd0)))
        else $error("rate flag disagrees with count");

    // Reset leaves no result on offer.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

endmodule

bind heartbeat_rate_detector hrd_checker u_hrd_checker (.*);
